// ----- sv/zrle_pkg.sv -----
// ----------------------------------------------------------------------------
// zrle_pkg
// Shared constants and controller/datapath interface types for the zero run
// length encoder.
// ----------------------------------------------------------------------------
package zrle_pkg;

   // Default cap on the length of one run
   localparam int MAX_RUN_DEF = 63;

   // Literal runs that carry held zeros are capped at this length
   localparam int MERGED_CAP = 15;

   // Zero runs shorter than this are held back for the next literal header, unless a finish closes them
   localparam int SHORT_ZERO_LIMIT = 8;

   // Header tags
   localparam logic [7:0] ZERO_HDR   = 8'h40;
   localparam logic [7:0] MERGED_HDR = 8'h80;

   // Item function codes
   localparam logic FUNC_DATA   = 1'b0;
   localparam logic FUNC_FINISH = 1'b1;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;    // latch the accepted item
      logic open;       // open a new run with the latched byte
      logic append;     // extend the open run with the latched byte
      logic hold;       // hold back the open (short) zero run
      logic emit_hdr;   // load the run header into the output register
      logic emit_lit;   // load the next stored literal into the output register
      logic close_run;  // run fully emitted: reopen with latched byte or end block
   } zrle_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic item_finish;  // latched item is a finish
      logic run_active;   // a run is open
      logic must_close;   // latched byte closes the open run
      logic run_is_zero;  // open run is a zero run
      logic short_zero;   // open run is shorter than the hold limit
      logic lit_last;     // current literal is the last of the run
      logic out_free;     // output register can take a byte this cycle
   } zrle_stat_type;

endpackage

// ----- sv/zrle_ctrl.sv -----
// ----------------------------------------------------------------------------
// zrle_ctrl
// Controller for the zero run length encoder: accepts items, decides what
// each one does to the open run and sequences header and literal output.
// ----------------------------------------------------------------------------
module zrle_ctrl
   import zrle_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  zrle_stat_type stat,
   output zrle_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_HDR,
      ST_LIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (ready_ff && req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (stat.item_finish) begin
               state_in = stat.run_active ? ST_HDR : ST_IDLE;
            end else if (!stat.run_active) begin
               cmd.open = 1'b1;
               state_in = ST_IDLE;
            end else if (!stat.must_close) begin
               cmd.append = 1'b1;
               state_in   = ST_IDLE;
            end else if (stat.run_is_zero && stat.short_zero) begin
               cmd.hold = 1'b1;
               cmd.open = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_HDR;
            end
         end
         ST_HDR: begin
            if (stat.out_free) begin
               cmd.emit_hdr = 1'b1;
               if (stat.run_is_zero) begin
                  cmd.close_run = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_LIT;
               end
            end
         end
         ST_LIT: begin
            if (stat.out_free) begin
               cmd.emit_lit = 1'b1;
               if (stat.lit_last) begin
                  cmd.close_run = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready = ready_ff;

endmodule

// ----- sv/zrle_dp.sv -----
// ----------------------------------------------------------------------------
// zrle_dp
// Datapath for the zero run length encoder: run state, literal buffer,
// header assembly and the output register.
// ----------------------------------------------------------------------------
module zrle_dp
   import zrle_pkg::*;
#(
   parameter int MAX_RUN = MAX_RUN_DEF
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_func,
   input  logic [7:0]    req_data_byte,
   input  zrle_cmd_type  cmd,
   output zrle_stat_type stat,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [7:0]    rsp_code_byte,
   output logic          rsp_last,
   output logic          rsp_block_end
);

   localparam int LEN_W  = $clog2(MAX_RUN + 1);
   localparam int ADDR_W = $clog2(MAX_RUN);

   // Latched item
   logic             item_func_ff;
   logic [7:0]       item_byte_ff;

   // Run state
   logic             run_active_ff, run_active_in;
   logic             run_is_zero_ff, run_is_zero_in;
   logic [LEN_W-1:0] run_length_ff, run_length_in;
   logic [2:0]       held_zeros_ff, held_zeros_in;

   // Literal buffer and read side
   logic [7:0]       lit_mem [MAX_RUN];
   logic [LEN_W-1:0] lit_idx_ff, lit_idx_in;
   logic [7:0]       rd_data_ff;
   logic             wr_en;
   logic [ADDR_W-1:0] wr_addr;

   // Output register
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_code_ff, out_code_in;
   logic             out_last_ff, out_last_in;
   logic             out_end_ff, out_end_in;

   logic             do_open;
   logic             item_zero;
   logic             lit_last;
   logic [7:0]       n_byte;
   logic [7:0]       zero_hdr;
   logic [7:0]       lit_hdr;

   assign item_zero = (item_byte_ff == 8'h00);
   assign do_open   = cmd.open || (cmd.close_run && (item_func_ff == FUNC_DATA));
   assign lit_last  = (LEN_W'(lit_idx_ff + 1'b1) == run_length_ff);

   // Assemble headers
   assign n_byte   = 8'(run_length_ff);
   assign zero_hdr = ZERO_HDR | n_byte;
   assign lit_hdr  = (held_zeros_ff != 3'd0)
                   ? (MERGED_HDR | {1'b0, held_zeros_ff, n_byte[3:0]})
                   : n_byte;

   // Report status
   always_comb begin
      stat.item_finish = (item_func_ff == FUNC_FINISH);
      stat.run_active  = run_active_ff;
      stat.must_close  = (item_zero != run_is_zero_ff)
                       || (run_length_ff >= LEN_W'(MAX_RUN))
                       || ((held_zeros_ff != 3'd0) && (run_length_ff >= LEN_W'(MERGED_CAP)));
      stat.run_is_zero = run_is_zero_ff;
      stat.short_zero  = (run_length_ff < LEN_W'(SHORT_ZERO_LIMIT));
      stat.lit_last    = lit_last;
      stat.out_free    = !out_valid_ff || rsp_ready;
   end

   // Update run state
   always_comb begin
      run_active_in  = run_active_ff;
      run_is_zero_in = run_is_zero_ff;
      run_length_in  = run_length_ff;
      held_zeros_in  = held_zeros_ff;
      if (cmd.hold) begin
         held_zeros_in = run_length_ff[2:0];
      end
      if (cmd.close_run) begin
         held_zeros_in = 3'd0;
         run_active_in = 1'b0;
         run_length_in = '0;
      end
      if (cmd.append) begin
         run_length_in = LEN_W'(run_length_ff + 1'b1);
      end
      if (do_open) begin
         run_active_in  = 1'b1;
         run_is_zero_in = item_zero;
         run_length_in  = LEN_W'(1);
      end
   end

   // Store literals: first byte at entry zero, later bytes at the run length
   assign wr_en   = !item_zero && (do_open || (cmd.append && !run_is_zero_ff));
   assign wr_addr = do_open ? '0 : run_length_ff[ADDR_W-1:0];

   // Advance literal index; rewind when the run is done
   always_comb begin
      lit_idx_in = lit_idx_ff;
      if (cmd.close_run) begin
         lit_idx_in = '0;
      end else if (cmd.emit_lit) begin
         lit_idx_in = LEN_W'(lit_idx_ff + 1'b1);
      end
   end

   // Load or drop the output register
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_code_in  = out_code_ff;
      out_last_in  = out_last_ff;
      out_end_in   = out_end_ff;
      if (cmd.emit_hdr) begin
         out_valid_in = 1'b1;
         out_code_in  = run_is_zero_ff ? zero_hdr : lit_hdr;
         out_last_in  = run_is_zero_ff;
         out_end_in   = run_is_zero_ff && (item_func_ff == FUNC_FINISH);
      end else if (cmd.emit_lit) begin
         out_valid_in = 1'b1;
         out_code_in  = rd_data_ff;
         out_last_in  = lit_last;
         out_end_in   = lit_last && (item_func_ff == FUNC_FINISH);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff  <= 1'b0;
         run_is_zero_ff <= 1'b0;
         run_length_ff  <= '0;
         held_zeros_ff  <= 3'd0;
         lit_idx_ff     <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         run_active_ff  <= run_active_in;
         run_is_zero_ff <= run_is_zero_in;
         run_length_ff  <= run_length_in;
         held_zeros_ff  <= held_zeros_in;
         lit_idx_ff     <= lit_idx_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_func_ff <= req_func;
         item_byte_ff <= req_data_byte;
      end
      out_code_ff <= out_code_in;
      out_last_ff <= out_last_in;
      out_end_ff  <= out_end_in;
   end

   // Literal buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         lit_mem[wr_addr] <= item_byte_ff;
      end
      rd_data_ff <= lit_mem[lit_idx_in[ADDR_W-1:0]];
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_code_byte = out_code_ff;
   assign rsp_last      = out_last_ff;
   assign rsp_block_end = out_end_ff;

   // Held zeros only ride on an open literal run within the merged cap
   a_held_on_literal: assert property (@(posedge clock) disable iff (reset)
      (held_zeros_ff != 3'd0) |-> (run_active_ff && !run_is_zero_ff
                                   && (run_length_ff <= LEN_W'(MERGED_CAP))))
      else $error("held zeros outside a literal run");

   // An open run is never empty and never beyond the cap
   a_run_length: assert property (@(posedge clock) disable iff (reset)
      run_active_ff |-> ((run_length_ff != '0) && (run_length_ff <= LEN_W'(MAX_RUN))))
      else $error("open run length out of range");

   // A block end is always the last byte of its item
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_end_ff) |-> out_last_ff)
      else $error("block end without last");

   // Literal index stays inside the run while literals are emitted
   a_lit_idx: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_lit |-> (lit_idx_ff < run_length_ff))
      else $error("literal index past run end");

endmodule

// ----- sv/zero_run_length_encoder.sv -----
// Each accepted item is latched and decided on; the header and literals of a
// run it closes then go out one byte per cycle while the receiver takes them,
// and req_ready stays low until the last one is in the single output register.
// Up to 64 code bytes (header plus 63 literals) follow one item.
// Reset clears run and handshake state; the literal buffer is not cleared.
// ----------------------------------------------------------------------------
// zero_run_length_encoder
// Encodes a byte stream as zero runs and literal runs, merging short zero
// runs into the following literal header; a finish item flushes the block.
// ----------------------------------------------------------------------------
module zero_run_length_encoder
   import zrle_pkg::*;
#(
   parameter int MAX_RUN = MAX_RUN_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_code_byte,
   output logic       rsp_last,
   output logic       rsp_block_end
);

   zrle_cmd_type  cmd;
   zrle_stat_type stat;

   // Sequence items and output
   zrle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold run state, literals and the output register
   zrle_dp #(
      .MAX_RUN (MAX_RUN)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_func      (req_func),
      .req_data_byte (req_data_byte),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_code_byte (rsp_code_byte),
      .rsp_last      (rsp_last),
      .rsp_block_end (rsp_block_end)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the zero run length encoder. A built-in predictor
// tracks the open run, the held short zero run and the literal buffer, and
// queues the code bytes each accepted byte or finish should produce. Directed
// runs cover the corner cases, then a random stream of well-formed runs with
// some noise follows, under random sender gaps, receiver stalls and one long
// output hold-off.
// ----------------------------------------------------------------------------
module tb_top
   import zrle_pkg::*;
();

   localparam int LONG_STALL     = 300;
   localparam int IDLE_LIMIT     = 2000;
   localparam int RANDOM_ITEMS   = 100;
   localparam int MAX_REPORTS    = 10;
   localparam int SETTLE_CYCLES  = 8;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
      logic       block_end;
   } code_beat_type;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_CYCLIC} ready_mode_type;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_ready;
   logic       req_func      = FUNC_DATA;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready     = 1'b0;
   logic [7:0] rsp_code_byte;
   logic       rsp_last;
   logic       rsp_block_end;

   // predictor state
   logic       run_open   = 1'b0;
   logic       run_zero   = 1'b0;
   logic [5:0] run_len    = '0;
   logic [2:0] zeros_held = '0;
   logic [7:0] literal_buf [0:MAX_RUN_DEF-1];
   code_beat_type code_bytes_due[$];

   int             fail_count   = 0;
   int             idle_cycles  = 0;
   int             burst_left   = 0;
   bit             gaps_on      = 1'b1;
   bit             long_stall_req = 1'b0;
   logic           rsp_hold     = 1'b0;
   ready_mode_type ready_mode   = READY_ALWAYS;
   int             mode_left    = 0;
   int             ready_phase  = 0;

   zero_run_length_encoder i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_code_byte (rsp_code_byte),
      .rsp_last      (rsp_last),
      .rsp_block_end (rsp_block_end)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // Encoding predictor
   // ------------------------------------------------------------------------
   function automatic void push_code(logic [7:0] value);
      code_beat_type beat;
      beat.code      = value;
      beat.last      = 1'b0;
      beat.block_end = 1'b0;
      code_bytes_due.push_back(beat);
   endfunction

   function automatic void start_run(logic [7:0] value);
      run_open = 1'b1;
      run_zero = (value == 8'h00);
      run_len  = 6'd1;
      if (!run_zero) begin
         literal_buf[0] = value;
      end
   endfunction

   // Close the open run; a short zero run is held back unless flushing
   function automatic void close_run_codes(bit flush);
      logic [7:0] header;
      if (run_zero) begin
         if (run_len < SHORT_ZERO_LIMIT && !flush) begin
            zeros_held = run_len[2:0];
         end else begin
            push_code(ZERO_HDR | {2'b00, run_len});
         end
      end else begin
         if (zeros_held != 0) begin
            header = MERGED_HDR | {1'b0, zeros_held, run_len[3:0]};
         end else begin
            header = {2'b00, run_len};
         end
         zeros_held = '0;
         push_code(header);
         for (int j = 0; j < run_len; j++) begin
            push_code(literal_buf[j]);
         end
      end
      run_len = '0;
   endfunction

   function automatic void encode_item(logic func, logic [7:0] value);
      int            due_before;
      code_beat_type tail;
      due_before = code_bytes_due.size();
      if (func == FUNC_FINISH) begin
         if (run_open) begin
            close_run_codes(1'b1);
            run_open   = 1'b0;
            zeros_held = '0;
         end
      end else if (!run_open) begin
         start_run(value);
      end else if (((value == 8'h00) != run_zero) || run_len >= MAX_RUN_DEF ||
                   (zeros_held != 0 && run_len >= MERGED_CAP)) begin
         close_run_codes(1'b0);
         start_run(value);
      end else begin
         if (!run_zero) begin
            literal_buf[run_len] = value;
         end
         run_len = run_len + 6'd1;
      end
      // tag the final byte of this item
      if (code_bytes_due.size() > due_before) begin
         tail = code_bytes_due.pop_back();
         tail.last = 1'b1;
         if (func == FUNC_FINISH) begin
            tail.block_end = 1'b1;
         end
         code_bytes_due.push_back(tail);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: predict on input transfer, compare on output transfer
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      code_beat_type due;
      if (!reset) begin
         if (req_valid && req_ready) begin
            encode_item(req_func, req_data_byte);
         end
         if (rsp_valid && rsp_ready) begin
            if (code_bytes_due.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("unexpected code byte %02h last %0b end %0b",
                           rsp_code_byte, rsp_last, rsp_block_end);
               end
            end else begin
               due = code_bytes_due.pop_front();
               if (rsp_code_byte !== due.code || rsp_last !== due.last ||
                   rsp_block_end !== due.block_end) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS) begin
                     $display("mismatch: expected %02h last %0b end %0b, got %02h last %0b end %0b",
                              due.code, due.last, due.block_end,
                              rsp_code_byte, rsp_last, rsp_block_end);
                  end
               end
            end
         end
      end
      // count cycles without any transfer
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Receiver: switch stall pattern at random, honor the long hold-off
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(10, 80);
      end else begin
         mode_left = mode_left - 1;
      end
      ready_phase = ready_phase + 1;
      if (rsp_hold) begin
         rsp_ready <= 1'b0;
      end else begin
         unique case (ready_mode)
            READY_ALWAYS: begin
               rsp_ready <= 1'b1;
            end
            READY_COIN: begin
               rsp_ready <= 1'($urandom_range(0, 1));
            end
            READY_SPARSE: begin
               rsp_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_ready <= (ready_phase % 3 != 2);
            end
         endcase
      end
   end

   // Hold the output off for a long stretch on request
   initial forever begin
      wait (long_stall_req);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (LONG_STALL) @(posedge clock);
      rsp_hold <= 1'b0;
      long_stall_req = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------------
   task automatic send_item(input logic func, input logic [7:0] value);
      int gap;
      // drop valid between bursts
      if (gaps_on && burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      req_valid     <= 1'b1;
      req_func      <= func;
      req_data_byte <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // Send a run of zeros or of random nonzero literals
   task automatic send_run(input bit zeros, input int count);
      for (int i = 0; i < count; i++) begin
         send_item(FUNC_DATA, zeros ? 8'h00 : 8'($urandom_range(1, 255)));
      end
   endtask

   task automatic send_finish();
      send_item(FUNC_FINISH, 8'($urandom_range(0, 255)));
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_empty_block();
      send_item(FUNC_FINISH, 8'h00);
      send_item(FUNC_FINISH, 8'hFF);
   endtask

   task automatic test_zero_runs();
      // shortest zero run that is never held back, then a short one flushed by finish
      send_run(1'b1, 8);
      send_item(FUNC_FINISH, 8'hA5);
      send_run(1'b1, 3);
      send_item(FUNC_FINISH, 8'h5A);
   endtask

   task automatic test_merged_header();
      send_item(FUNC_DATA, 8'h00);
      send_item(FUNC_DATA, 8'h00);
      send_item(FUNC_DATA, 8'hFF);
      send_item(FUNC_DATA, 8'h01);
      send_item(FUNC_DATA, 8'h80);
      send_item(FUNC_DATA, 8'h00);
      send_item(FUNC_DATA, 8'h7F);
      send_item(FUNC_FINISH, 8'h00);
   endtask

   task automatic test_plain_literals();
      send_item(FUNC_DATA, 8'h55);
      send_item(FUNC_DATA, 8'hAA);
      send_item(FUNC_FINISH, 8'hFF);
   endtask

   task automatic test_run_caps();
      // literal run past its cap
      send_run(1'b0, MAX_RUN_DEF + 1);
      send_finish();
      // zero run past its cap
      send_run(1'b1, MAX_RUN_DEF + 1);
      send_finish();
      // merged literal run past its cap
      send_run(1'b1, 7);
      send_run(1'b0, MERGED_CAP + 1);
      send_finish();
   endtask

   task automatic test_backpressure();
      // keep offering literal and zero runs while the output is held off
      gaps_on        = 1'b0;
      long_stall_req = 1'b1;
      send_run(1'b0, 20);
      send_run(1'b1, 2);
      send_run(1'b0, 12);
      send_run(1'b1, 3);
      send_finish();
      gaps_on = 1'b1;
   endtask

   task automatic test_random_stream();
      int sent;
      int pick;
      int count;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_finish();
            count = 1;
         end else if (pick < 15) begin
            // noise: any byte, zero included
            send_item(FUNC_DATA, 8'($urandom_range(0, 255)));
            count = 1;
         end else if (pick < 55) begin
            count = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 7)
                                              : $urandom_range(8, 66);
            send_run(1'b1, count);
         end else begin
            count = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 16)
                                              : $urandom_range(17, 66);
            send_run(1'b0, count);
         end
         sent += count;
      end
      send_finish();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_empty_block();
      test_zero_runs();
      test_merged_header();
      test_plain_literals();
      test_run_caps();
      test_backpressure();
      test_random_stream();
      req_valid <= 1'b0;
      // let the monitor see the last transfer, drain, then let the block settle
      @(posedge clock);
      while (code_bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- zero_run_length_encoder.f -----
sv/zrle_pkg.sv
sv/zrle_ctrl.sv
sv/zrle_dp.sv
sv/zero_run_length_encoder.sv
tb/tb_top.sv
